/* design/cts_pkg.sv */
// ---------------------------------------------------------------------------
// cts_pkg
// Shared constants, codes, width helpers and types for the cosine top-k search.
// ---------------------------------------------------------------------------
package cts_pkg;

    localparam int MAX_DIM_DEF  = 256;
    localparam int MAX_KEEP_DEF = 16;
    localparam int QUEUE_DEPTH  = 4;

    localparam int OP_W       = 2;
    localparam int ELEM_W     = 16;
    localparam int ID_W       = 16;
    localparam int SCORE_W    = 16;
    localparam int RANK_W     = 4;
    localparam int FRAC_BITS  = 15;
    localparam int VLEN_W     = 9;
    localparam int LIMIT_W    = 5;
    localparam int SCOPE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_CAND   = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCOPE_MODE    = 2'd2;

    localparam logic [SCOPE_W-1:0] SCOPE_WORKSPACE = 2'd1;
    localparam logic [SCOPE_W-1:0] SCOPE_DEPS      = 2'd2;

    localparam logic [VLEN_W-1:0]  VLEN_RESET  = 9'd256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;
    localparam logic [SCOPE_W-1:0] SCOPE_RESET = 2'd0;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

    typedef struct packed {
        logic empty;
        logic room;
    } q_stat_t;

    function automatic int idx_w(input int d);
        return (d > 1) ? $clog2(d) : 1;
    endfunction

    // signed dot product sum
    function automatic int acc_w(input int d);
        return 32 + $clog2(d);
    endfunction

    // unsigned squared norm sum
    function automatic int nrm_w(input int d);
        return 31 + $clog2(d);
    endfunction

    function automatic int rt_w(input int d);
        return (nrm_w(d) + 1) >> 1;
    endfunction

    function automatic int cnt_w(input int k);
        return $clog2(k + 1);
    endfunction

endpackage

/* design/cts_in_if.sv */
// ---------------------------------------------------------------------------
// cts_in_if
// Input channel: query elements, candidate elements and finish commands.
// ---------------------------------------------------------------------------
interface cts_in_if;
    logic                                valid;
    logic                                ready;
    logic [cts_pkg::OP_W-1:0]            operation;
    logic signed [cts_pkg::ELEM_W-1:0]   element;
    logic [cts_pkg::ID_W-1:0]            symbol_id;
    logic                                is_dependency;
    logic                                has_embedding;

    modport source (
        output valid, operation, element, symbol_id, is_dependency, has_embedding,
        input  ready
    );
    modport sink (
        input  valid, operation, element, symbol_id, is_dependency, has_embedding,
        output ready
    );
endinterface

/* design/cts_out_if.sv */
// ---------------------------------------------------------------------------
// cts_out_if
// Result channel: ranked hits emitted on finish.
// ---------------------------------------------------------------------------
interface cts_out_if;
    logic                                valid;
    logic                                ready;
    logic [cts_pkg::ID_W-1:0]            result_id;
    logic signed [cts_pkg::SCORE_W-1:0]  score;
    logic [cts_pkg::RANK_W-1:0]          rank;
    logic                                empty_res;
    logic                                last;

    modport source (
        output valid, result_id, score, rank, empty_res, last,
        input  ready
    );
    modport sink (
        input  valid, result_id, score, rank, empty_res, last,
        output ready
    );
endinterface

/* design/cts_front.sv */
// ---------------------------------------------------------------------------
// cts_front
// Element pipeline: query store, multiply stage and accumulators; hands
// scored-candidate and finish jobs to the queue.
// ---------------------------------------------------------------------------
module cts_front #(
    parameter int MAX_DIM = cts_pkg::MAX_DIM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cts_in_if.sink                             in_ch,
    input  logic [cts_pkg::VLEN_W-1:0]         vector_length,
    input  logic [cts_pkg::SCOPE_W-1:0]        scope_mode,
    input  cts_pkg::q_stat_t                   q_stat,
    output logic                               push,
    output logic [1 + cts_pkg::ID_W + cts_pkg::acc_w(MAX_DIM)
                  + 2 * cts_pkg::nrm_w(MAX_DIM) - 1:0] job
);

    localparam int IDX_W = cts_pkg::idx_w(MAX_DIM);
    localparam int LEN_W = $clog2(MAX_DIM + 1);
    localparam int ACC_W = cts_pkg::acc_w(MAX_DIM);
    localparam int NRM_W = cts_pkg::nrm_w(MAX_DIM);
    localparam int EW    = cts_pkg::ELEM_W;
    localparam int PW    = 2 * EW;

    logic signed [EW-1:0] qmem [MAX_DIM];

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] len_eff;
    logic             accept, live, final_el;

    logic                         s1_valid_reg;
    logic [cts_pkg::OP_W-1:0]     s1_op_reg;
    logic signed [EW-1:0]         s1_e_reg;
    logic signed [EW-1:0]         s1_q_reg;
    logic [cts_pkg::ID_W-1:0]     s1_id_reg;
    logic                         s1_dep_reg, s1_first_reg, s1_final_reg;

    logic                         s2_valid_reg;
    logic [cts_pkg::OP_W-1:0]     s2_op_reg;
    logic [cts_pkg::ID_W-1:0]     s2_id_reg;
    logic                         s2_dep_reg, s2_first_reg, s2_final_reg;
    logic signed [PW-1:0]         s2_pd_reg;
    logic [PW-2:0]                s2_pn_reg;

    logic signed [PW-1:0]         prod_d, prod_n;

    logic signed [ACC_W-1:0]      dot_reg, dot_sum;
    logic [NRM_W-1:0]             qn_reg, cn_reg, cn_sum, qn_sum;
    logic                         in_scope, s2_finish, s2_cand, s2_query;

    assign in_ch.ready = q_stat.room;
    assign accept      = in_ch.valid & in_ch.ready;

    always_comb
    begin
        if (vector_length == '0)
            len_eff = LEN_W'(1);
        else if (32'(vector_length) > 32'(MAX_DIM))
            len_eff = LEN_W'(MAX_DIM);
        else
            len_eff = LEN_W'(vector_length);
    end

    assign final_el = (32'(idx_reg) + 32'd1) >= 32'(len_eff);
    assign live     = (in_ch.operation == cts_pkg::OP_QUERY)
                    | (in_ch.operation == cts_pkg::OP_FINISH)
                    | ((in_ch.operation == cts_pkg::OP_CAND) & in_ch.has_embedding);

    always_comb
    begin
        idx_next = idx_reg;
        if (accept && live)
        begin
            if (in_ch.operation == cts_pkg::OP_FINISH || final_el)
                idx_next = '0;
            else
                idx_next = idx_reg + IDX_W'(1);
        end
    end

    // query store: written and read at the shared element index
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (in_ch.operation == cts_pkg::OP_QUERY)
                qmem[idx_reg] <= in_ch.element;
            s1_q_reg <= qmem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            s1_valid_reg <= accept & live;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= in_ch.operation;
            s1_e_reg     <= in_ch.element;
            s1_id_reg    <= in_ch.symbol_id;
            s1_dep_reg   <= in_ch.is_dependency;
            s1_first_reg <= (idx_reg == '0);
            s1_final_reg <= final_el;
        end
    end

    assign prod_d = s1_q_reg * s1_e_reg;
    assign prod_n = s1_e_reg * s1_e_reg;

    always_ff @(posedge clk)
    begin
        s2_op_reg    <= s1_op_reg;
        s2_id_reg    <= s1_id_reg;
        s2_dep_reg   <= s1_dep_reg;
        s2_first_reg <= s1_first_reg;
        s2_final_reg <= s1_final_reg;
        s2_pd_reg    <= prod_d;
        s2_pn_reg    <= prod_n[PW-2:0];
    end

    assign s2_query  = s2_valid_reg & (s2_op_reg == cts_pkg::OP_QUERY);
    assign s2_cand   = s2_valid_reg & (s2_op_reg == cts_pkg::OP_CAND);
    assign s2_finish = s2_valid_reg & (s2_op_reg == cts_pkg::OP_FINISH);

    assign dot_sum = (s2_first_reg ? '0 : dot_reg) + ACC_W'(s2_pd_reg);
    assign cn_sum  = (s2_first_reg ? '0 : cn_reg) + NRM_W'(s2_pn_reg);
    assign qn_sum  = (s2_first_reg ? '0 : qn_reg) + NRM_W'(s2_pn_reg);

    assign in_scope = !(((scope_mode == cts_pkg::SCOPE_WORKSPACE) && s2_dep_reg)
                     || ((scope_mode == cts_pkg::SCOPE_DEPS) && !s2_dep_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            qn_reg  <= '0;
            cn_reg  <= '0;
        end
        else
        begin
            if (s2_query)
                qn_reg <= qn_sum;
            if (s2_cand)
            begin
                dot_reg <= dot_sum;
                cn_reg  <= cn_sum;
            end
        end
    end

    assign push = s2_finish | (s2_cand & s2_final_reg & in_scope);
    assign job  = {s2_finish, s2_id_reg, dot_sum, qn_reg, cn_sum};

endmodule

/* design/cts_queue.sv */
// ---------------------------------------------------------------------------
// cts_queue
// Short job queue between the element pipeline and the scoring engine.
// ---------------------------------------------------------------------------
module cts_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cts_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              pop,
    output logic [WIDTH-1:0]  rd_data,
    output cts_pkg::q_stat_t  q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign rd_data      = slot_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    // up to two jobs may still be in flight in the element pipeline
    assign q_stat.room  = (32'(count_reg) + 3) <= DEPTH;

endmodule

/* design/cts_back.sv */
// ---------------------------------------------------------------------------
// cts_back
// Scoring engine: serial square roots, serial divide, sorted insertion and
// result emission.
// ---------------------------------------------------------------------------
module cts_back #(
    parameter int MAX_DIM  = cts_pkg::MAX_DIM_DEF,
    parameter int MAX_KEEP = cts_pkg::MAX_KEEP_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cts_pkg::q_stat_t                   q_stat,
    input  logic [1 + cts_pkg::ID_W + cts_pkg::acc_w(MAX_DIM)
                  + 2 * cts_pkg::nrm_w(MAX_DIM) - 1:0] job,
    output logic                               pop,
    input  logic [cts_pkg::LIMIT_W-1:0]        result_limit,
    cts_out_if.source                          out_ch
);

    localparam int ACC_W = cts_pkg::acc_w(MAX_DIM);
    localparam int NRM_W = cts_pkg::nrm_w(MAX_DIM);
    localparam int RT_W  = cts_pkg::rt_w(MAX_DIM);
    localparam int PAD_W = 2 * RT_W;
    localparam int RW    = RT_W + 3;
    localparam int DEN_W = 2 * RT_W;
    localparam int BIG_W = (ACC_W > DEN_W) ? ACC_W : DEN_W;
    localparam int QB    = cts_pkg::FRAC_BITS;
    localparam int SC_W  = $clog2(RT_W + 1);
    localparam int KC_W  = cts_pkg::cnt_w(MAX_KEEP);
    localparam int KI_W  = cts_pkg::idx_w(MAX_KEEP);
    localparam int IDW   = cts_pkg::ID_W;
    localparam int SW    = cts_pkg::SCORE_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ROOT   = 7'b0000010,
        S_MULT   = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_INSERT = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic                    job_finish;
    logic [IDW-1:0]          job_id;
    logic signed [ACC_W-1:0] job_dot;
    logic [NRM_W-1:0]        job_qn, job_cn;

    logic [IDW-1:0]          id_reg;
    logic                    neg_reg;
    logic [ACC_W-1:0]        mag_reg;
    logic [PAD_W-1:0]        qv_reg, cv_reg;
    logic [RW-1:0]           qrem_reg, crem_reg;
    logic [RT_W-1:0]         qroot_reg, croot_reg;
    logic [SC_W-1:0]         step_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [QB-1:0]           quo_reg;
    logic signed [SW-1:0]    score_reg;

    logic [IDW-1:0]          kept_id_reg [MAX_KEEP];
    logic signed [SW-1:0]    kept_sc_reg [MAX_KEEP];
    logic [KC_W-1:0]         kept_cnt_reg;
    logic [KC_W-1:0]         emit_k_reg, emit_n_reg;

    logic                    out_valid_reg;
    logic [IDW-1:0]          out_id_reg;
    logic signed [SW-1:0]    out_score_reg;
    logic [cts_pkg::RANK_W-1:0] out_rank_reg;
    logic                    out_empty_reg, out_last_reg;

    logic [KC_W-1:0]         lim, cur;
    logic [MAX_KEEP-1:0]     ge;
    logic                    ins;

    logic [RW-1:0]           q_rs, q_tr, c_rs, c_tr;
    logic [DEN_W:0]          r2;
    logic                    qbit;
    logic [QB-1:0]           quo_new;
    logic                    out_free, emit_last;

    assign {job_finish, job_id, job_dot, job_qn, job_cn} = job;

    always_comb
    begin
        if (32'(result_limit) > MAX_KEEP)
            lim = KC_W'(MAX_KEEP);
        else
            lim = KC_W'(result_limit);
        cur = (kept_cnt_reg < lim) ? kept_cnt_reg : lim;
    end

    // root step: bring down two radicand bits, try (root*4 + 1)
    assign q_rs = {qrem_reg[RT_W:0], qv_reg[PAD_W-1 -: 2]};
    assign q_tr = RW'({qroot_reg, 2'b01});
    assign c_rs = {crem_reg[RT_W:0], cv_reg[PAD_W-1 -: 2]};
    assign c_tr = RW'({croot_reg, 2'b01});

    assign r2      = {rem_reg, 1'b0};
    assign qbit    = r2 >= {1'b0, den_reg};
    assign quo_new = {quo_reg[QB-2:0], qbit};

    // sorted insertion: entries at or above the new score stay put
    always_comb
    begin
        ins = 1'b0;
        for (int j = 0; j < MAX_KEEP; j++)
        begin
            ge[j] = (32'(j) < 32'(cur)) && (kept_sc_reg[j] >= score_reg);
            if ((32'(j) < 32'(lim)) && !ge[j])
                ins = 1'b1;
        end
    end

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign emit_last = (emit_n_reg == '0) || ((emit_k_reg + KC_W'(1)) == emit_n_reg);

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    state_next = job_finish ? S_EMIT : S_ROOT;
                end
            S_ROOT:
                if (32'(step_reg) == RT_W - 1)
                    state_next = S_MULT;
            S_MULT:
                state_next = S_CHECK;
            S_CHECK:
                if (den_reg == '0 || BIG_W'(mag_reg) >= BIG_W'(den_reg))
                    state_next = S_INSERT;
                else
                    state_next = S_DIV;
            S_DIV:
                if (32'(step_reg) == QB - 1)
                    state_next = S_INSERT;
            S_INSERT:
                state_next = S_IDLE;
            S_EMIT:
                if (out_free && emit_last)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kept_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_INSERT)
            begin
                if (lim == '0)
                    kept_cnt_reg <= '0;
                else
                    kept_cnt_reg <= cur + KC_W'(ins && (cur < lim));
            end
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (emit_last)
                    kept_cnt_reg <= '0;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                id_reg     <= job_id;
                neg_reg    <= job_dot[ACC_W-1];
                mag_reg    <= job_dot[ACC_W-1] ? ACC_W'(-job_dot) : ACC_W'(job_dot);
                qv_reg     <= PAD_W'(job_qn);
                cv_reg     <= PAD_W'(job_cn);
                qrem_reg   <= '0;
                crem_reg   <= '0;
                qroot_reg  <= '0;
                croot_reg  <= '0;
                step_reg   <= '0;
                emit_k_reg <= '0;
                emit_n_reg <= cur;
            end
            S_ROOT:
            begin
                qv_reg   <= qv_reg << 2;
                cv_reg   <= cv_reg << 2;
                step_reg <= step_reg + SC_W'(1);
                if (q_rs >= q_tr)
                begin
                    qrem_reg  <= q_rs - q_tr;
                    qroot_reg <= {qroot_reg[RT_W-2:0], 1'b1};
                end
                else
                begin
                    qrem_reg  <= q_rs;
                    qroot_reg <= {qroot_reg[RT_W-2:0], 1'b0};
                end
                if (c_rs >= c_tr)
                begin
                    crem_reg  <= c_rs - c_tr;
                    croot_reg <= {croot_reg[RT_W-2:0], 1'b1};
                end
                else
                begin
                    crem_reg  <= c_rs;
                    croot_reg <= {croot_reg[RT_W-2:0], 1'b0};
                end
            end
            S_MULT:
                den_reg <= qroot_reg * croot_reg;
            S_CHECK:
            begin
                rem_reg  <= DEN_W'(mag_reg);
                quo_reg  <= '0;
                step_reg <= '0;
                if (den_reg == '0)
                    score_reg <= '0;
                else if (neg_reg)
                    score_reg <= cts_pkg::SCORE_MIN;
                else
                    score_reg <= cts_pkg::SCORE_MAX;
            end
            S_DIV:
            begin
                rem_reg  <= qbit ? DEN_W'(r2 - {1'b0, den_reg}) : DEN_W'(r2);
                quo_reg  <= quo_new;
                step_reg <= step_reg + SC_W'(1);
                if (neg_reg)
                    score_reg <= -$signed({1'b0, quo_new});
                else
                    score_reg <= $signed({1'b0, quo_new});
            end
            S_INSERT:
            begin
                for (int j = 0; j < MAX_KEEP; j++)
                begin
                    if ((32'(j) < 32'(lim)) && !ge[j])
                    begin
                        if (j == 0 || ge[(j == 0) ? 0 : j - 1])
                        begin
                            kept_id_reg[j] <= id_reg;
                            kept_sc_reg[j] <= score_reg;
                        end
                        else
                        begin
                            kept_id_reg[j] <= kept_id_reg[(j == 0) ? 0 : j - 1];
                            kept_sc_reg[j] <= kept_sc_reg[(j == 0) ? 0 : j - 1];
                        end
                    end
                end
            end
            S_EMIT:
                if (out_free)
                begin
                    emit_k_reg   <= emit_k_reg + KC_W'(1);
                    out_last_reg <= emit_last;
                    if (emit_n_reg == '0)
                    begin
                        out_id_reg    <= '0;
                        out_score_reg <= '0;
                        out_rank_reg  <= '0;
                        out_empty_reg <= 1'b1;
                    end
                    else
                    begin
                        out_id_reg    <= kept_id_reg[emit_k_reg[KI_W-1:0]];
                        out_score_reg <= kept_sc_reg[emit_k_reg[KI_W-1:0]];
                        out_rank_reg  <= cts_pkg::RANK_W'(emit_k_reg);
                        out_empty_reg <= 1'b0;
                    end
                end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.result_id = out_id_reg;
    assign out_ch.score     = out_score_reg;
    assign out_ch.rank      = out_rank_reg;
    assign out_ch.empty_res = out_empty_reg;
    assign out_ch.last      = out_last_reg;

endmodule

/* design/cosine_topk_search.sv */
// Scoring: a candidate job passes the root, multiply, check, divide and insert states
//   in that order (no divide when the score saturates or the denominator is zero).
// Throughput: one element per cycle while at most one job waits in the queue;
//   the engine scores one queued job at a time.
// Finish: a finish job goes from the queue straight to result emission.
// Reset: control, accumulators and list count cleared; query store undefined.
// ---------------------------------------------------------------------------
// cosine_topk_search
// Cosine-similarity top-k search over streamed Q1.15 vectors.
// ---------------------------------------------------------------------------
module cosine_topk_search #(
    parameter int MAX_DIM  = cts_pkg::MAX_DIM_DEF,
    parameter int MAX_KEEP = cts_pkg::MAX_KEEP_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cts_in_if.sink                            in_ch,
    cts_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cts_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int JOB_W = 1 + cts_pkg::ID_W + cts_pkg::acc_w(MAX_DIM)
                         + 2 * cts_pkg::nrm_w(MAX_DIM);

    logic [cts_pkg::VLEN_W-1:0]  vlen_reg;
    logic [cts_pkg::LIMIT_W-1:0] limit_reg;
    logic [cts_pkg::SCOPE_W-1:0] scope_reg;

    logic             push, pop;
    logic [JOB_W-1:0] job_in, job_out;
    cts_pkg::q_stat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg  <= cts_pkg::VLEN_RESET;
            limit_reg <= cts_pkg::LIMIT_RESET;
            scope_reg <= cts_pkg::SCOPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cts_pkg::REG_VECTOR_LENGTH: vlen_reg  <= cfg_data[cts_pkg::VLEN_W-1:0];
                cts_pkg::REG_RESULT_LIMIT:  limit_reg <= cfg_data[cts_pkg::LIMIT_W-1:0];
                cts_pkg::REG_SCOPE_MODE:    scope_reg <= cfg_data[cts_pkg::SCOPE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    cts_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .vector_length (vlen_reg),
        .scope_mode    (scope_reg),
        .q_stat        (q_stat),
        .push          (push),
        .job           (job_in)
    );

    cts_queue #(
        .WIDTH (JOB_W),
        .DEPTH (cts_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (job_in),
        .pop     (pop),
        .rd_data (job_out),
        .q_stat  (q_stat)
    );

    cts_back #(
        .MAX_DIM  (MAX_DIM),
        .MAX_KEEP (MAX_KEEP)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .job          (job_out),
        .pop          (pop),
        .result_limit (limit_reg),
        .out_ch       (out_ch)
    );

endmodule
